// ===== hdl/nze_pkg.sv =====
// shared types and constants for the nonzero index extractor
`timescale 1ns / 1ps

package nze_pkg;

  localparam int PACKED_DIMS  = 4;
  localparam int DEF_MAX_DIMS = 4;
  localparam int COORD_W      = 16;
  localparam int OFFS_W       = 64;
  localparam int CNT_W        = 64;
  localparam int ELEM_W       = 8;
  localparam int NDIM_W       = 3;
  localparam int APB_DATA_W   = 64;
  localparam int APB_ADDR_W   = 6;

  localparam logic [NDIM_W-1:0]            NUM_DIMS_RST = NDIM_W'(1);
  localparam logic [PACKED_DIMS*COORD_W-1:0] EXTENTS_RST = 64'h0001_0001_0001_0001;

  typedef enum logic [2:0] {
    REG_NUM_DIMS = 3'd0,
    REG_EXTENTS  = 3'd1,
    REG_WEIGHT_0 = 3'd2,
    REG_WEIGHT_1 = 3'd3,
    REG_WEIGHT_2 = 3'd4,
    REG_WEIGHT_3 = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [NDIM_W-1:0]                    num_dims;
    logic [PACKED_DIMS*COORD_W-1:0]       extents;
    logic [PACKED_DIMS-1:0][OFFS_W-1:0]   weights;
  } cfg_t;

  // element snapshot between the counter stage and the offset stage
  typedef struct packed {
    logic [PACKED_DIMS-1:0][COORD_W-1:0]  coords;
    logic [PACKED_DIMS-1:0][OFFS_W-1:0]   prods;
    logic                                 hit;
    logic                                 last;
    logic [CNT_W-1:0]                     count;
  } stage_t;

endpackage

// ===== hdl/nze_cfg_regs.sv =====
// apb configuration registers of the nonzero index extractor
`timescale 1ns / 1ps

module nze_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nze_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nze_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nze_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output nze_pkg::cfg_t                  cfg
);
  import nze_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_dims <= NUM_DIMS_RST;
      cfg_r.extents  <= EXTENTS_RST;
      cfg_r.weights  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NUM_DIMS: cfg_r.num_dims   <= pwdata[NDIM_W-1:0];
        REG_EXTENTS:  cfg_r.extents    <= pwdata;
        REG_WEIGHT_0: cfg_r.weights[0] <= pwdata;
        REG_WEIGHT_1: cfg_r.weights[1] <= pwdata;
        REG_WEIGHT_2: cfg_r.weights[2] <= pwdata;
        REG_WEIGHT_3: cfg_r.weights[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NUM_DIMS: prdata = APB_DATA_W'(cfg_r.num_dims);
      REG_EXTENTS:  prdata = cfg_r.extents;
      REG_WEIGHT_0: prdata = cfg_r.weights[0];
      REG_WEIGHT_1: prdata = cfg_r.weights[1];
      REG_WEIGHT_2: prdata = cfg_r.weights[2];
      REG_WEIGHT_3: prdata = cfg_r.weights[3];
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== hdl/nze_coord_ctrl.sv =====
// coordinate counters, nonzero count and per-dimension products
`timescale 1ns / 1ps

module nze_coord_ctrl #(
  parameter int MAX_DIMS = nze_pkg::DEF_MAX_DIMS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  nze_pkg::cfg_t              cfg,
  input  logic                       in_fire,
  input  logic [nze_pkg::ELEM_W-1:0] element_value,
  input  logic                       stage_take,
  output logic                       stage_valid,
  output nze_pkg::stage_t            stage
);
  import nze_pkg::*;

  localparam int ACT_DIMS = (MAX_DIMS < PACKED_DIMS) ? MAX_DIMS : PACKED_DIMS;

  logic [COORD_W-1:0]                   coord_r   [ACT_DIMS];
  logic [COORD_W-1:0]                   coord_nxt [ACT_DIMS];
  logic [CNT_W-1:0]                     count_r;
  logic [CNT_W-1:0]                     count_sum;
  logic [NDIM_W-1:0]                    nd;
  logic [PACKED_DIMS-1:0][COORD_W-1:0]  cval;
  logic [PACKED_DIMS-1:0][COORD_W-1:0]  ext;
  logic [PACKED_DIMS-1:0]               at_end;
  logic [PACKED_DIMS-1:0][OFFS_W-1:0]   prod;
  logic                                 hit;
  logic                                 last;
  logic                                 carry;
  logic                                 stage_valid_r;
  stage_t                               stage_r;
  stage_t                               stage_nxt;

  // dimensions in use: zero means scalar, saturate at what is built
  always_comb begin
    nd = (cfg.num_dims == '0) ? NDIM_W'(1) : cfg.num_dims;
    if (nd > NDIM_W'(ACT_DIMS)) nd = NDIM_W'(ACT_DIMS);
  end

  for (genvar d = 0; d < PACKED_DIMS; d++) begin : g_dim
    if (d < ACT_DIMS) begin : g_used
      assign cval[d] = (NDIM_W'(d) < nd) ? coord_r[d] : '0;
    end else begin : g_unused
      assign cval[d] = '0;
    end
    assign ext[d]    = (cfg.extents[COORD_W*d +: COORD_W] == '0) ? COORD_W'(1)
                                                                  : cfg.extents[COORD_W*d +: COORD_W];
    // a coordinate at or past its extent minus one sits at the end
    assign at_end[d] = (NDIM_W'(d) >= nd) || (cval[d] >= ext[d] - COORD_W'(1));
    assign prod[d]   = OFFS_W'(cval[d] * cfg.weights[d]);
  end

  assign hit       = |element_value;
  assign last      = &at_end;
  assign count_sum = count_r + CNT_W'(hit);

  always_comb begin
    carry = 1'b1;
    for (int d = 0; d < ACT_DIMS; d++) begin
      coord_nxt[d] = coord_r[d];
      if ((NDIM_W'(d) < nd) && carry) begin
        if (at_end[d]) begin
          coord_nxt[d] = '0;
        end else begin
          coord_nxt[d] = coord_r[d] + COORD_W'(1);
          carry        = 1'b0;
        end
      end
      if (last) coord_nxt[d] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < ACT_DIMS; d++) coord_r[d] <= '0;
      count_r <= '0;
    end else if (in_fire) begin
      for (int d = 0; d < ACT_DIMS; d++) coord_r[d] <= coord_nxt[d];
      count_r <= last ? '0 : count_sum;
    end
  end

  always_comb begin
    stage_nxt.coords = cval;
    stage_nxt.prods  = prod;
    stage_nxt.hit    = hit;
    stage_nxt.last   = last;
    stage_nxt.count  = count_sum;
  end

  // zero elements that are not last leave no entry here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_fire) begin
      stage_valid_r <= hit || last;
    end else if (stage_take) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) stage_r <= stage_nxt;
  end

  assign stage_valid = stage_valid_r;
  assign stage       = stage_r;

endmodule

// ===== hdl/nze_offset_out.sv =====
// offset adder and result register
`timescale 1ns / 1ps

module nze_offset_out (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 stage_valid,
  input  nze_pkg::stage_t                                      stage,
  output logic                                                 stage_take,
  input  logic                                                 out_stall,
  output logic                                                 out_valid,
  output logic [nze_pkg::PACKED_DIMS-1:0][nze_pkg::COORD_W-1:0] out_coord,
  output logic signed [nze_pkg::OFFS_W-1:0]                    out_linear_offset,
  output logic                                                 out_hit,
  output logic [nze_pkg::CNT_W-1:0]                            out_nonzero_count,
  output logic                                                 out_done_res
);
  import nze_pkg::*;

  logic                                 out_valid_r;
  logic [PACKED_DIMS-1:0][COORD_W-1:0]  coord_r;
  logic [OFFS_W-1:0]                    offset_r;
  logic [OFFS_W-1:0]                    offset_nxt;
  logic                                 hit_r;
  logic [CNT_W-1:0]                     count_r;
  logic                                 done_r;

  assign stage_take = stage_valid && (!out_valid_r || !out_stall);

  // wraps modulo 2^64
  always_comb begin
    offset_nxt = '0;
    for (int d = 0; d < PACKED_DIMS; d++) offset_nxt = offset_nxt + stage.prods[d];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take) begin
      coord_r  <= stage.coords;
      offset_r <= offset_nxt;
      hit_r    <= stage.hit;
      count_r  <= stage.count;
      done_r   <= stage.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_coord         = coord_r;
  assign out_linear_offset = offset_r;
  assign out_hit           = hit_r;
  assign out_nonzero_count = count_r;
  assign out_done_res      = done_r;

endmodule

// ===== hdl/nonzero_index_extractor.sv =====
// top level of the nonzero index extractor
`timescale 1ns / 1ps

// Streams a tensor of up to four dimensions, one element byte per transfer with dimension 0
// fastest, and returns a result for each nonzero element (coordinates, 64-bit wrapping
// weighted offset, running nonzero count) plus one result with done_res set on the tensor's
// last element, after which coordinates and count clear. A new element is taken every cycle
// while the result side keeps up. The coordinate counter and the 16x64 multiplies feed a stage
// register at the edge that accepts the element; the offset adder feeds the result register
// from the stage register when the result side takes the stage. While the output stalls, one
// result waits in the stage register and one on the output, and the input stalls until the
// stage can move on. Zero elements other than the last produce no result. Configuration goes
// over the apb port, one 64-bit register every 8 bytes, and is to be written by the user only
// while the block is idle; the block itself does not enforce this.
module nonzero_index_extractor #(
  parameter int MAX_DIMS = nze_pkg::DEF_MAX_DIMS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [nze_pkg::ELEM_W-1:0]     in_element_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [nze_pkg::COORD_W-1:0]    out_coord_0,
  output logic [nze_pkg::COORD_W-1:0]    out_coord_1,
  output logic [nze_pkg::COORD_W-1:0]    out_coord_2,
  output logic [nze_pkg::COORD_W-1:0]    out_coord_3,
  output logic signed [nze_pkg::OFFS_W-1:0] out_linear_offset,
  output logic                           out_hit,
  output logic [nze_pkg::CNT_W-1:0]      out_nonzero_count,
  output logic                           out_done_res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nze_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nze_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nze_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import nze_pkg::*;

  cfg_t                                 cfg;
  stage_t                               stage;
  logic                                 stage_valid;
  logic                                 stage_take;
  logic                                 in_fire;
  logic [PACKED_DIMS-1:0][COORD_W-1:0]  coord_vec;

  nze_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage holds unless the result side takes it this cycle
  assign in_stall = stage_valid && !stage_take;
  assign in_fire  = in_valid && !in_stall;

  nze_coord_ctrl #(
    .MAX_DIMS (MAX_DIMS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_fire       (in_fire),
    .element_value (in_element_value),
    .stage_take    (stage_take),
    .stage_valid   (stage_valid),
    .stage         (stage)
  );

  nze_offset_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .stage_valid       (stage_valid),
    .stage             (stage),
    .stage_take        (stage_take),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_coord         (coord_vec),
    .out_linear_offset (out_linear_offset),
    .out_hit           (out_hit),
    .out_nonzero_count (out_nonzero_count),
    .out_done_res      (out_done_res)
  );

  assign out_coord_0 = coord_vec[0];
  assign out_coord_1 = coord_vec[1];
  assign out_coord_2 = coord_vec[2];
  assign out_coord_3 = coord_vec[3];

  // a result without a hit can only be the end of a tensor
  a_miss_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_done_res)
    else $error("result without hit and without done");

  // an empty result register never holds back the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  // an accepted element that is nonzero, taken while no result is waiting, lands in the offset stage
  a_hit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_element_value != '0) && !out_valid |=> stage_valid)
    else $error("nonzero element lost before offset stage");

endmodule
